@@ sv/vapt_pkg.sv @@
// shared types and constants for the valve actuator position tracker
package vapt_pkg;

  // width of the elapsed time counter
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned CUR_BITS  = 16;
  localparam int unsigned ACT_BITS  = 32;
  // wide enough to compare the elapsed count against the actuation limit
  localparam int unsigned WIDE_BITS = (TIME_BITS > ACT_BITS) ? TIME_BITS : ACT_BITS;

  typedef enum logic [1:0] {
    CMD_POWER   = 2'd0,
    CMD_DIR     = 2'd1,
    CMD_CURRENT = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    VS_CLOSED  = 3'd0,
    VS_OPENING = 3'd1,
    VS_OPENED  = 3'd2,
    VS_CLOSING = 3'd3,
    VS_UNKNOWN = 3'd4
  } valve_e;

  typedef struct packed {
    cmd_e                cmd;
    logic                relay_on;
    logic [CUR_BITS-1:0] current_ma;
  } item_t;

  typedef struct packed {
    valve_e              valve_state;
    logic                state_changed;
    logic [CUR_BITS-1:0] peak_current_ma;
    logic [ACT_BITS-1:0] actuation_ms;
  } result_t;

  // handshake between the input stage and the result stage
  typedef struct packed {
    logic item_valid;
    logic advance;
  } flow_t;

endpackage

@@ sv/vapt_if.sv @@
// channel interfaces for command items and tracker results
interface vapt_in_if;
  import vapt_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  logic                relay_on;
  logic [CUR_BITS-1:0] current_ma;

  modport source (output valid, output cmd, output relay_on, output current_ma,
                  input ready);
  modport sink (input valid, input cmd, input relay_on, input current_ma,
                output ready);
endinterface

interface vapt_out_if;
  import vapt_pkg::*;
  logic                valid;
  logic                ready;
  logic [2:0]          valve_state;
  logic                state_changed;
  logic [CUR_BITS-1:0] peak_current_ma;
  logic [ACT_BITS-1:0] actuation_ms;

  modport source (output valid, output valve_state, output state_changed,
                  output peak_current_ma, output actuation_ms, input ready);
  modport sink (input valid, input valve_state, input state_changed,
                input peak_current_ma, input actuation_ms, output ready);
endinterface

@@ sv/valve_actuator_position_tracker_core.sv @@
// top level of the valve actuator position tracker
//
//   channel  dir  signals                                          per transaction
//   in_i     in   cmd, relay_on, current_ma                        one command
//   out_o    out  valve_state, state_changed, peak_current_ma,     one result
//                 actuation_ms
//
// one command per cycle sustained while out_o is ready; a result is offered once
// its command has passed through the input register and then the result register.
// tracker state updates as an item passes from input to result register.
// reset (rst_ni low) gives valve state unknown, relays off, counters zero.
// a stall on out_o holds the result register and, behind it, the input register.
module valve_actuator_position_tracker_core
  import vapt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  vapt_in_if.sink    in_i,
  vapt_out_if.source out_o
);

  item_t   in_item;
  item_t   stage_item;
  result_t upd_result;
  result_t out_result;
  flow_t   flow;
  logic    out_space;

  always_comb begin
    in_item.cmd        = cmd_e'(in_i.cmd);
    in_item.relay_on   = in_i.relay_on;
    in_item.current_ma = in_i.current_ma;
  end

  // item moves on when the result register has room
  assign flow.advance = flow.item_valid && out_space;

  vapt_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .ready_o      (in_i.ready),
    .item_i       (in_item),
    .advance_i    (flow.advance),
    .item_valid_o (flow.item_valid),
    .item_o       (stage_item)
  );

  vapt_update u_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (flow.advance),
    .item_i   (stage_item),
    .result_o (upd_result)
  );

  vapt_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (flow.advance),
    .result_i (upd_result),
    .space_o  (out_space),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .result_o (out_result)
  );

  assign out_o.valve_state     = out_result.valve_state;
  assign out_o.state_changed   = out_result.state_changed;
  assign out_o.peak_current_ma = out_result.peak_current_ma;
  assign out_o.actuation_ms    = out_result.actuation_ms;

endmodule

@@ sv/vapt_in_stage.sv @@
// input register stage holding one command item
module vapt_in_stage
  import vapt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  item_t  item_i,
  input  logic   advance_i,
  output logic   item_valid_o,
  output item_t  item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  // stage is free when empty or when its item moves on this cycle
  assign ready_o = !valid_q || advance_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  assign item_d = take ? item_i : item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload carries no reset
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ sv/vapt_update.sv @@
// tracker state registers and the per-command update logic
module vapt_update
  import vapt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t result_o
);

  valve_e               state_q, state_d;
  logic                 power_q, power_d;
  logic                 dir_q, dir_d;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic [CUR_BITS-1:0]  peak_q, peak_d;
  logic [ACT_BITS-1:0]  act_q, act_d;

  logic                 enter;
  valve_e               target;
  logic                 changed;
  logic [WIDE_BITS-1:0] elapsed_wide;
  logic [ACT_BITS-1:0]  elapsed_act;
  valve_e               moving;

  // elapsed count clipped to the actuation field
  assign elapsed_wide = WIDE_BITS'(elapsed_q);
  assign elapsed_act  = (elapsed_wide > WIDE_BITS'({ACT_BITS{1'b1}})) ?
                        {ACT_BITS{1'b1}} : elapsed_wide[ACT_BITS-1:0];
  assign moving       = dir_q ? VS_OPENING : VS_CLOSING;

  // command decode
  always_comb begin
    power_d   = power_q;
    dir_d     = dir_q;
    peak_d    = peak_q;
    act_d     = act_q;
    elapsed_d = elapsed_q;
    enter     = 1'b0;
    target    = state_q;
    case (item_i.cmd)
      CMD_POWER: begin
        if (item_i.relay_on != power_q) begin
          power_d = item_i.relay_on;
          if (item_i.relay_on) begin
            peak_d = '0;
            act_d  = '0;
            enter  = 1'b1;
            target = moving;
          end
        end
      end
      CMD_DIR: begin
        if (item_i.relay_on != dir_q) begin
          dir_d = item_i.relay_on;
          if (power_q) begin
            act_d  = '0;
            enter  = 1'b1;
            target = item_i.relay_on ? VS_OPENING : VS_CLOSING;
          end
        end
      end
      CMD_CURRENT: begin
        if (item_i.current_ma != '0) begin
          if (item_i.current_ma > peak_q) begin
            peak_d = item_i.current_ma;
          end
          act_d  = elapsed_act;
          enter  = 1'b1;
          target = moving;
        end else if (state_q == VS_OPENING) begin
          act_d  = elapsed_act;
          enter  = 1'b1;
          target = VS_OPENED;
        end else if (state_q == VS_CLOSING) begin
          act_d  = elapsed_act;
          enter  = 1'b1;
          target = VS_CLOSED;
        end
      end
      CMD_TICK: begin
        if (elapsed_q != {TIME_BITS{1'b1}}) begin
          elapsed_d = elapsed_q + TIME_BITS'(1);
        end
      end
      default: begin
        enter = 1'b0;
      end
    endcase
  end

  // a real state change restarts the elapsed counter
  assign changed = enter && (target != state_q);
  assign state_d = changed ? target : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= VS_UNKNOWN;
      power_q   <= 1'b0;
      dir_q     <= 1'b0;
      elapsed_q <= '0;
      peak_q    <= '0;
      act_q     <= '0;
    end else if (fire_i) begin
      state_q   <= state_d;
      power_q   <= power_d;
      dir_q     <= dir_d;
      elapsed_q <= changed ? '0 : elapsed_d;
      peak_q    <= peak_d;
      act_q     <= act_d;
    end
  end

  // result reflects the state after this item
  always_comb begin
    result_o.valve_state     = state_d;
    result_o.state_changed   = changed;
    result_o.peak_current_ma = peak_d;
    result_o.actuation_ms    = act_d;
  end

  // a state change always restarts elapsed time
  a_change_clears_elapsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && changed |=> elapsed_q == '0)
    else $error("elapsed time not cleared on state change");

  // peak only drops when power turns on
  a_peak_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.cmd != CMD_POWER |=> peak_q >= $past(peak_q))
    else $error("peak current decreased without power on");

  // unknown is never re-entered once left
  a_unknown_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != VS_UNKNOWN |=> state_q != VS_UNKNOWN)
    else $error("valve state returned to unknown");

  // nothing moves without a transaction
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(state_q) && $stable(elapsed_q) && $stable(peak_q))
    else $error("tracker state changed without a transaction");

endmodule

@@ sv/vapt_out_stage.sv @@
// result register stage feeding the output channel
module vapt_out_stage
  import vapt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    space_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q, result_d;

  // room when empty or when the held result leaves this cycle
  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  assign result_d = load_i ? result_i : result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

@@ sim/valve_actuator_position_tracker_core_tb.sv @@
// testbench for the valve actuator position tracker, checked against a local tracker model
module valve_actuator_position_tracker_core_tb;
  import vapt_pkg::*;

  localparam int LONG_HOLD      = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TOTAL_ITEMS    = 750;

  logic clk;
  logic rst_n;

  vapt_in_if  in_ch ();
  vapt_out_if out_ch ();

  valve_actuator_position_tracker_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // tracker model state
  valve_e               trk_state;
  logic                 trk_power;
  logic                 trk_dir;
  logic [TIME_BITS-1:0] trk_elapsed;
  logic [CUR_BITS-1:0]  trk_peak;
  logic [ACT_BITS-1:0]  trk_act;

  result_t pending_results[$];
  int      mismatch_count = 0;
  int      items_sent     = 0;
  int      idle_cycles    = 0;
  bit      send_idle_on   = 1'b1;
  bit      recv_idle_on   = 1'b1;
  bit      hold_req       = 1'b0;
  int      stall_left     = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // elapsed time as it is recorded, clamped to the actuation width
  function automatic logic [ACT_BITS-1:0] elapsed_clamped();
    logic [WIDE_BITS-1:0] e;
    e = WIDE_BITS'(trk_elapsed);
    if (e > WIDE_BITS'({ACT_BITS{1'b1}})) return {ACT_BITS{1'b1}};
    return e[ACT_BITS-1:0];
  endfunction

  // move to a new valve state, restarting the elapsed count on a change
  function automatic logic go_state(valve_e s);
    if (s == trk_state) return 1'b0;
    trk_state   = s;
    trk_elapsed = '0;
    return 1'b1;
  endfunction

  // one command through the tracker model, giving the result it causes
  function automatic result_t track_valve(item_t it);
    result_t r;
    logic    chg;
    valve_e  moving;
    chg = 1'b0;
    case (it.cmd)
      CMD_POWER: begin
        if (it.relay_on != trk_power) begin
          trk_power = it.relay_on;
          if (trk_power) begin
            trk_peak = '0;
            trk_act  = '0;
            chg = go_state(trk_dir ? VS_OPENING : VS_CLOSING);
          end
        end
      end
      CMD_DIR: begin
        if (it.relay_on != trk_dir) begin
          trk_dir = it.relay_on;
          if (trk_power) begin
            trk_act = '0;
            chg = go_state(trk_dir ? VS_OPENING : VS_CLOSING);
          end
        end
      end
      CMD_CURRENT: begin
        moving = trk_dir ? VS_OPENING : VS_CLOSING;
        if (it.current_ma != '0) begin
          if (it.current_ma > trk_peak) trk_peak = it.current_ma;
          trk_act = elapsed_clamped();
          chg = go_state(moving);
        end else if (trk_state == VS_OPENING) begin
          trk_act = elapsed_clamped();
          chg = go_state(VS_OPENED);
        end else if (trk_state == VS_CLOSING) begin
          trk_act = elapsed_clamped();
          chg = go_state(VS_CLOSED);
        end
      end
      default: begin
        if (trk_elapsed != {TIME_BITS{1'b1}}) trk_elapsed = trk_elapsed + TIME_BITS'(1);
      end
    endcase
    r.valve_state     = trk_state;
    r.state_changed   = chg;
    r.peak_current_ma = trk_peak;
    r.actuation_ms    = trk_act;
    return r;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap(bit idle_on);
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // current value with the extremes favored
  function automatic logic [CUR_BITS-1:0] rand_current(bit nonzero);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0 && !nonzero) return '0;
    if (r == 1) return {CUR_BITS{1'b1}};
    if (r == 2) return CUR_BITS'(1);
    return CUR_BITS'($urandom_range(1, 65535));
  endfunction

  // random relay level
  function automatic logic rand_level();
    return 1'($urandom_range(0, 1));
  endfunction

  // offer one command and wait until the block takes it
  task automatic send_cmd(input cmd_e c, input logic lvl, input logic [CUR_BITS-1:0] cur);
    int    gap;
    item_t it;
    gap = pick_gap(send_idle_on);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.cmd        = c;
    it.relay_on   = lvl;
    it.current_ma = cur;
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.relay_on   <= lvl;
    in_ch.current_ma <= cur;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(track_valve(it));
    items_sent++;
  endtask

  task automatic send_random_item();
    send_cmd(cmd_e'(2'($urandom_range(0, 3))), rand_level(), rand_current(1'b0));
  endtask

  // one valve movement: direction, power on, motion, current drops, power off
  task automatic run_stroke();
    int n;
    int r;
    send_cmd(CMD_DIR, rand_level(), rand_current(1'b0));
    send_cmd(CMD_POWER, 1'b1, rand_current(1'b0));
    n = $urandom_range(2, 10);
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r < 5) send_cmd(CMD_TICK, rand_level(), rand_current(1'b0));
      else if (r < 8) send_cmd(CMD_CURRENT, rand_level(), rand_current(1'b1));
      else if (r < 9) send_cmd(CMD_DIR, rand_level(), rand_current(1'b0));
      else send_random_item();
    end
    send_cmd(CMD_CURRENT, rand_level(), '0);
    repeat ($urandom_range(0, 3)) send_cmd(CMD_TICK, rand_level(), rand_current(1'b0));
    send_cmd(CMD_POWER, 1'b0, rand_current(1'b0));
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // each command kind, relay edges and repeats, current extremes, unused bits
  task automatic test_directed();
    send_cmd(CMD_TICK, 1'b0, '0);
    send_cmd(CMD_CURRENT, 1'b0, '0);             // zero current while unknown
    send_cmd(CMD_POWER, 1'b0, '0);               // same level again
    send_cmd(CMD_DIR, 1'b1, '0);                 // direction with power off
    send_cmd(CMD_POWER, 1'b1, '0);               // power on edge, opening
    repeat (3) send_cmd(CMD_TICK, 1'b0, '0);
    send_cmd(CMD_CURRENT, 1'b0, 16'hffff);       // peak at full scale
    send_cmd(CMD_CURRENT, 1'b1, 16'h0001);
    send_cmd(CMD_TICK, 1'b0, '0);
    send_cmd(CMD_CURRENT, 1'b0, '0);             // opening finishes as opened
    send_cmd(CMD_DIR, 1'b0, '0);                 // direction change with power on
    send_cmd(CMD_DIR, 1'b0, '0);
    send_cmd(CMD_TICK, 1'b0, '0);
    send_cmd(CMD_CURRENT, 1'b0, '0);             // closing finishes as closed
    send_cmd(CMD_CURRENT, 1'b0, '0);             // zero current while closed
    send_cmd(CMD_POWER, 1'b0, 16'h5a5a);         // power off edge
    send_cmd(CMD_CURRENT, 1'b1, 16'h8000);       // current with power off
    send_cmd(CMD_POWER, 1'b1, 16'hffff);         // power on with state already closing
    send_cmd(CMD_DIR, 1'b1, 16'hffff);
    send_cmd(CMD_TICK, 1'b1, 16'hffff);          // unused fields all ones
    send_cmd(CMD_CURRENT, 1'b0, 16'h7fff);
    send_cmd(CMD_POWER, 1'b0, '0);
  endtask

  // mostly well-formed movements with some noise in between
  task automatic test_random(input int upto);
    while (items_sent < upto) begin
      if ($urandom_range(0, 3) != 0) run_stroke();
      else repeat ($urandom_range(1, 6)) send_random_item();
    end
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    send_idle_on = 1'b0;
    hold_req     = 1'b1;
    repeat (30) send_random_item();
    send_idle_on = 1'b1;
  endtask

  // sender pauses until the block has returned everything
  task automatic test_pause();
    run_stroke();
    drain_results();
    repeat (4) @(posedge clk);
    run_stroke();
  endtask

  // a stretch with no idling on either side
  task automatic test_full_rate();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    repeat (2) run_stroke();
    repeat (40) send_random_item();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // result receiver with random and long hold-offs
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap(recv_idle_on);
      end
    end
  end

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, got state %0d", $time, out_ch.valve_state);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("valve_state", 64'(exp_r.valve_state), 64'(out_ch.valve_state));
        check_field("state_changed", 64'(exp_r.state_changed), 64'(out_ch.state_changed));
        check_field("peak_current_ma", 64'(exp_r.peak_current_ma),
                    64'(out_ch.peak_current_ma));
        check_field("actuation_ms", 64'(exp_r.actuation_ms), 64'(out_ch.actuation_ms));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // main sequence
  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_TICK;
    in_ch.relay_on   <= 1'b0;
    in_ch.current_ma <= '0;
    trk_state   = VS_UNKNOWN;
    trk_power   = 1'b0;
    trk_dir     = 1'b0;
    trk_elapsed = '0;
    trk_peak    = '0;
    trk_act     = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(560);
    test_backpressure();
    test_pause();
    test_full_rate();
    test_random(TOTAL_ITEMS);

    drain_results();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/vapt_pkg.sv
sv/vapt_if.sv
sv/vapt_in_stage.sv
sv/vapt_update.sv
sv/vapt_out_stage.sv
sv/valve_actuator_position_tracker_core.sv
sim/valve_actuator_position_tracker_core_tb.sv
